>>> design/ofv_pkg.sv
// ofv_pkg: shared types and constants for the optical flow frame velocity block
// frame codes, register indexes, datapath widths and the sequencer state type
// no dependencies
package ofv_pkg;

   localparam int PAYLOAD_LEN = 10;
   localparam int POS_W       = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int NUM_W       = 36;
   localparam int SUM_W       = 37;
   localparam int ACC_W       = 53;
   localparam int OUT_W       = 48;
   localparam int MULT_W      = 16;
   localparam int CNT_W       = 6;

   localparam logic [7:0] HDR0 = 8'hFE;
   localparam logic [7:0] HDR1 = 8'h0A;
   localparam logic [7:0] TAIL = 8'h55;

   localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

   localparam logic [POS_W-1:0] POS_HDR0     = 4'd0;
   localparam logic [POS_W-1:0] POS_HDR1     = 4'd1;
   localparam logic [POS_W-1:0] POS_PAYLOAD  = 4'd2;
   localparam logic [POS_W-1:0] POS_CHECKSUM = 4'd12;
   localparam logic [POS_W-1:0] POS_TAIL     = 4'd13;

   localparam logic [CNT_W-1:0] DIV_LAST = 6'd35;
   localparam logic [CNT_W-1:0] MUL_LAST = 6'd15;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT_OFFSET  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEADBAND_FLOOR = 2'd1;

   localparam logic [7:0] HEIGHT_OFFSET_RESET  = 8'd5;
   localparam logic [7:0] DEADBAND_FLOOR_RESET = 8'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_SUM,
      ST_MUL,
      ST_SAT,
      ST_DONE
   } state_type;

endpackage

>>> design/optical_flow_frame_velocity.sv
// optical_flow_frame_velocity: flow sensor frame parser with velocity sequencer
// uses ofv_pkg for frame codes, widths and the sequencer state type
//
// usage:
//   req channel: one received serial byte per request, with the current height
//   estimate, its valid flag and the body rates; valid/ready handshake.
//   rsp channel: one result per frame with a good header, checksum and tail.
//   csr port: csr_write with csr_index 0 (height offset) or 1 (deadband floor).
//   header, payload and checksum bytes never stall the parser; ready stays high.
//   a good tail starts the sequencer: per axis a load step, a restoring
//   divider, an add step, a shift-add multiplier and a saturate step, and
//   then the velocity result is loaded; an unavailable report skips the
//   sequencer. the single divider and multiplier step are shared by both
//   axes. req_ready is low while it runs.
//   results sit in an output register; a stalled receiver holds the finished
//   result there, and the block waits before loading the next one.
//   synchronous reset returns the parser to header hunt, clears the checksum,
//   sets both registers to 5 and drops rsp_valid.
module optical_flow_frame_velocity (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_rx_byte,
   input  logic signed [15:0]                req_height_cm,
   input  logic                              req_height_valid,
   input  logic signed [31:0]                req_rate_x,
   input  logic signed [31:0]                req_rate_y,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_velocity_ok,
   output logic signed [47:0]                rsp_vel_x,
   output logic signed [47:0]                rsp_vel_y,
   output logic [15:0]                       rsp_ground_reading,
   output logic [7:0]                        rsp_sensor_version,
   input  logic                              csr_write,
   input  logic [ofv_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ofv_pkg::CSR_DATA_W-1:0]    csr_data
);
   import ofv_pkg::*;

   state_type               state_ff, state_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [7:0]              xor_ff, xor_in;
   logic [7:0]              payload_ff [PAYLOAD_LEN];
   logic [7:0]              payload_in [PAYLOAD_LEN];
   logic [7:0]              offset_ff, offset_in;
   logic [7:0]              floor_ff, floor_in;
   logic signed [31:0]      rate_x_ff, rate_x_in;
   logic signed [31:0]      rate_y_ff, rate_y_in;
   logic [MULT_W-1:0]       mult_ff, mult_in;
   logic [MULT_W-1:0]       mbits_ff, mbits_in;
   logic                    sel_ff, sel_in;
   logic                    neg_ff, neg_in;
   logic                    ok_ff, ok_in;
   logic [NUM_W-1:0]        quo_ff, quo_in;
   logic [15:0]             rem_ff, rem_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [ACC_W-1:0] mcand_ff, mcand_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [OUT_W-1:0] velx_ff, velx_in;
   logic signed [OUT_W-1:0] vely_ff, vely_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic signed [OUT_W-1:0] rsp_velx_ff, rsp_velx_in;
   logic signed [OUT_W-1:0] rsp_vely_ff, rsp_vely_in;
   logic [15:0]             rsp_ground_ff, rsp_ground_in;
   logic [7:0]              rsp_version_ff, rsp_version_in;

   logic [15:0]             flow_x, flow_y, timespan, flow_sel, flow_mag;
   logic [NUM_W-1:0]        num_mag;
   logic [17:0]             trial;
   logic signed [SUM_W-1:0] addend, quo_signed, sum;
   logic signed [16:0]      deadband;
   logic                    below_floor;
   logic [MULT_W-1:0]       mult_new;
   logic                    frame_ok;
   logic                    overflow;
   logic signed [OUT_W-1:0] sat_value;

   assign flow_x   = {payload_ff[1], payload_ff[0]};
   assign flow_y   = {payload_ff[3], payload_ff[2]};
   assign timespan = {payload_ff[5], payload_ff[4]};

   // numerator magnitude for the current axis
   assign flow_sel = sel_ff ? flow_y : flow_x;
   assign flow_mag = flow_sel[15] ? (~flow_sel + 16'd1) : flow_sel;
   assign num_mag  = {20'd0, flow_mag} * {16'd0, USEC_PER_SEC};

   // restoring divider step
   assign trial = {1'b0, rem_ff, quo_ff[NUM_W-1]} - {2'b00, timespan};

   assign addend     = sel_ff ? -SUM_W'(rate_x_ff) : SUM_W'(rate_y_ff);
   assign quo_signed = {1'b0, quo_ff};
   assign sum        = neg_ff ? (addend - quo_signed) : (addend + quo_signed);

   // deadband gain from the tail request
   assign deadband    = {req_height_cm[15], req_height_cm} - {9'd0, offset_ff};
   assign below_floor = deadband < $signed({9'd0, floor_ff});
   assign mult_new    = below_floor ? 16'd1 : (deadband[15:0] + 16'd1);
   assign frame_ok    = req_height_valid && (payload_ff[8] != 8'd0) && (timespan != 16'd0);

   assign overflow  = (acc_ff[ACC_W-1:OUT_W-1] != {(ACC_W-OUT_W+1){1'b0}}) &&
                      (acc_ff[ACC_W-1:OUT_W-1] != {(ACC_W-OUT_W+1){1'b1}});
   assign sat_value = overflow ? (acc_ff[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                                  : {1'b0, {(OUT_W-1){1'b1}}})
                               : acc_ff[OUT_W-1:0];

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      xor_in         = xor_ff;
      payload_in     = payload_ff;
      offset_in      = offset_ff;
      floor_in       = floor_ff;
      rate_x_in      = rate_x_ff;
      rate_y_in      = rate_y_ff;
      mult_in        = mult_ff;
      mbits_in       = mbits_ff;
      sel_in         = sel_ff;
      neg_in         = neg_ff;
      ok_in          = ok_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      mcand_in       = mcand_ff;
      acc_in         = acc_ff;
      velx_in        = velx_ff;
      vely_in        = vely_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_velx_in    = rsp_velx_ff;
      rsp_vely_in    = rsp_vely_ff;
      rsp_ground_in  = rsp_ground_ff;
      rsp_version_in = rsp_version_ff;
      req_ready      = (state_ff == ST_IDLE);

      if (csr_write) begin
         if (csr_index == CSR_HEIGHT_OFFSET) begin
            offset_in = csr_data;
         end else if (csr_index == CSR_DEADBAND_FLOOR) begin
            floor_in = csr_data;
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority if (pos_ff == POS_HDR0) begin
                  if (req_rx_byte == HDR0) begin
                     pos_in = POS_HDR1;
                     xor_in = 8'd0;
                  end else begin
                     pos_in = POS_HDR0;
                  end
               end else if (pos_ff == POS_HDR1) begin
                  if (req_rx_byte == HDR1) begin
                     pos_in = POS_PAYLOAD;
                     xor_in = 8'd0;
                  end else begin
                     pos_in = POS_HDR0;
                  end
               end else if (pos_ff < POS_CHECKSUM) begin
                  for (int i = 0; i < PAYLOAD_LEN; i++) begin
                     if (pos_ff == POS_W'(i + 2)) begin
                        payload_in[i] = req_rx_byte;
                     end
                  end
                  xor_in = xor_ff ^ req_rx_byte;
                  pos_in = pos_ff + 4'd1;
               end else if (pos_ff == POS_CHECKSUM) begin
                  pos_in = (xor_ff == req_rx_byte) ? POS_TAIL : POS_HDR0;
               end else begin
                  pos_in = POS_HDR0;
                  if (req_rx_byte == TAIL) begin
                     rate_x_in = req_rate_x;
                     rate_y_in = req_rate_y;
                     mult_in   = mult_new;
                     ok_in     = frame_ok;
                     sel_in    = 1'b0;
                     if (frame_ok) begin
                        state_in = ST_LOAD;
                     end else begin
                        velx_in  = '0;
                        vely_in  = '0;
                        state_in = ST_DONE;
                     end
                  end
               end
            end
         end
         ST_LOAD: begin
            quo_in   = num_mag;
            rem_in   = 16'd0;
            cnt_in   = '0;
            neg_in   = sel_ff ? (!flow_y[15] && (flow_y != 16'd0)) : flow_x[15];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!trial[17]) begin
               rem_in = trial[15:0];
            end else begin
               rem_in = {rem_ff[14:0], quo_ff[NUM_W-1]};
            end
            quo_in = {quo_ff[NUM_W-2:0], ~trial[17]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            mcand_in = ACC_W'(sum);
            acc_in   = '0;
            mbits_in = mult_ff;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mbits_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in = mcand_ff <<< 1;
            mbits_in = mbits_ff >> 1;
            cnt_in   = cnt_ff + 6'd1;
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            if (!sel_ff) begin
               velx_in  = sat_value;
               sel_in   = 1'b1;
               state_in = ST_LOAD;
            end else begin
               vely_in  = sat_value;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_ok_in      = ok_ff;
               rsp_velx_in    = velx_ff;
               rsp_vely_in    = vely_ff;
               rsp_ground_in  = {payload_ff[7], payload_ff[6]};
               rsp_version_in = payload_ff[9];
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= POS_HDR0;
         xor_ff       <= 8'd0;
         offset_ff    <= HEIGHT_OFFSET_RESET;
         floor_ff     <= DEADBAND_FLOOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         xor_ff       <= xor_in;
         offset_ff    <= offset_in;
         floor_ff     <= floor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff     <= payload_in;
      rate_x_ff      <= rate_x_in;
      rate_y_ff      <= rate_y_in;
      mult_ff        <= mult_in;
      mbits_ff       <= mbits_in;
      sel_ff         <= sel_in;
      neg_ff         <= neg_in;
      ok_ff          <= ok_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      cnt_ff         <= cnt_in;
      mcand_ff       <= mcand_in;
      acc_ff         <= acc_in;
      velx_ff        <= velx_in;
      vely_ff        <= vely_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_velx_ff    <= rsp_velx_in;
      rsp_vely_ff    <= rsp_vely_in;
      rsp_ground_ff  <= rsp_ground_in;
      rsp_version_ff <= rsp_version_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_velocity_ok    = rsp_ok_ff;
   assign rsp_vel_x          = rsp_velx_ff;
   assign rsp_vel_y          = rsp_vely_ff;
   assign rsp_ground_reading = rsp_ground_ff;
   assign rsp_sensor_version = rsp_version_ff;

endmodule
